// ===== src/trl_pkg.sv =====
// Shared types and constants for the tag report rate limiter.
package trl_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W     = 48;
    localparam int TIME_W     = 63;
    localparam int INTERVAL_W = 32;
    localparam int SLOT_W     = 5;

    // The interval in microseconds needs 32 + 10 bits.
    localparam int NEED_W = 42;

    // Microseconds per millisecond.
    localparam logic [NEED_W-1:0] US_PER_MS = NEED_W'(1000);

    // Interval register value after reset, in milliseconds.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(5000);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input beat and restart the scan
        logic scan;    // read the next table entry
        logic calc;    // pick the slot, form the elapsed time and the limit
        logic decide;  // compare elapsed time against the limit
        logic commit;  // write the table entry and load the result register
    } trl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the last table entry is being read
        logic out_free;   // the result register can take a new beat
    } trl_sts_t;

endpackage

// ===== src/trl_ctrl.sv =====
// Controller state machine that sequences the scan, the decision and the write-back.
module trl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  trl_pkg::trl_sts_t sts,
    output trl_pkg::trl_cmd_t cmd
);
    import trl_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last entry read is evaluated during this cycle.
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/trl_datapath.sv =====
// Datapath: address table, scan evaluation, rate check and result register.
module trl_datapath #(
    parameter int CACHE_ENTRIES = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  trl_pkg::trl_cmd_t                  cmd,
    output trl_pkg::trl_sts_t                  sts,
    input  logic [trl_pkg::ADDR_W-1:0]         s_tag_address,
    input  logic [trl_pkg::TIME_W-1:0]         s_now_us,
    input  logic                               cfg_valid,
    input  logic [trl_pkg::INTERVAL_W-1:0]     cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_publish,
    output logic                               m_hit,
    output logic                               m_evicted,
    output logic [trl_pkg::SLOT_W-1:0]         m_slot
);
    import trl_pkg::*;

    localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int WORD_W = ADDR_W + TIME_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

    // Table storage: address and last report time per entry, valid bits in flops.
    logic [WORD_W-1:0]        entry_mem [CACHE_ENTRIES];
    logic [WORD_W-1:0]        rdata_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [TIME_W-1:0]     now_reg;

    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             eval_vld_reg;

    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [TIME_W-1:0] oldest_time_reg;
    logic [IDX_W-1:0] oldest_idx_reg;

    logic [TIME_W:0]   diff_reg;
    logic [NEED_W-1:0] need_reg;
    logic [IDX_W-1:0]  slot_idx_reg;
    logic              evict_reg;
    logic              publish_reg;

    logic              m_valid_reg;
    logic              m_publish_reg;
    logic              m_hit_reg;
    logic              m_evicted_reg;
    logic [SLOT_W-1:0] m_slot_reg;

    logic              ent_valid;
    logic [ADDR_W-1:0] ent_addr;
    logic [TIME_W-1:0] ent_time;
    logic              ent_first;
    logic [TIME_W-1:0] last_sel;
    logic [IDX_W-1:0]  slot_sel;
    logic [TIME_W:0]   diff_next;
    logic [NEED_W-1:0] need_next;
    logic              publish_next;
    logic [TIME_W-1:0] wr_time;

    assign sts.scan_last = (rd_idx_reg == IDX_LAST);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Fields of the entry read in the previous cycle.
    assign ent_valid = valid_reg[eval_idx_reg];
    assign ent_addr  = rdata_reg[WORD_W-1:TIME_W];
    assign ent_time  = rdata_reg[TIME_W-1:0];
    assign ent_first = (eval_idx_reg == '0);

    // Slot choice and the report time it starts from; a newly taken entry starts at zero.
    assign last_sel = hit_found_reg ? hit_time_reg : '0;
    always_comb begin
        priority if (hit_found_reg) begin
            slot_sel = hit_idx_reg;
        end else if (free_found_reg) begin
            slot_sel = free_idx_reg;
        end else begin
            slot_sel = oldest_idx_reg;
        end
    end

    // Elapsed time with borrow, and the interval in microseconds.
    assign diff_next = {1'b0, now_reg} - {1'b0, last_sel};
    assign need_next = NEED_W'(interval_reg) * US_PER_MS;

    // A negative elapsed time never passes unless the interval is zero.
    assign publish_next = (interval_reg == '0)
                       || (!diff_reg[TIME_W] && (diff_reg[TIME_W-1:0] >= TIME_W'(need_reg)));

    assign wr_time = publish_reg ? now_reg : last_sel;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            entry_mem[slot_idx_reg] <= {addr_reg, wr_time};
        end
        rdata_reg <= entry_mem[rd_idx_reg];
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit) begin
            valid_reg[slot_idx_reg] <= 1'b1;
        end
    end

    // Interval register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_valid) begin
            interval_reg <= cfg_data;
        end
    end

    // Input capture and scan address.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_tag_address;
            now_reg  <= s_now_us;
        end
        eval_idx_reg <= rd_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg   <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.scan;
            if (cmd.load) begin
                rd_idx_reg <= '0;
            end else if (cmd.scan && !sts.scan_last) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // Scan evaluation: first match, first free entry, oldest report time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (eval_vld_reg) begin
            if (ent_valid && (ent_addr == addr_reg) && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (!ent_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_vld_reg) begin
            if (ent_valid && (ent_addr == addr_reg) && !hit_found_reg) begin
                hit_idx_reg  <= eval_idx_reg;
                hit_time_reg <= ent_time;
            end
            if (!ent_valid && !free_found_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
            // Strict compare keeps the lowest index on ties.
            if (ent_first || (ent_time < oldest_time_reg)) begin
                oldest_time_reg <= ent_time;
                oldest_idx_reg  <= eval_idx_reg;
            end
        end
    end

    // Slot, elapsed time and limit, then the report decision.
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            diff_reg     <= diff_next;
            need_reg     <= need_next;
            slot_idx_reg <= slot_sel;
            evict_reg    <= !hit_found_reg && !free_found_reg;
        end
        if (cmd.decide) begin
            publish_reg <= publish_next;
        end
    end

    // Result register; a new beat can load while the old one leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_publish_reg <= publish_reg;
            m_hit_reg     <= hit_found_reg;
            m_evicted_reg <= evict_reg;
            m_slot_reg    <= SLOT_W'(slot_idx_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_publish = m_publish_reg;
    assign m_hit     = m_hit_reg;
    assign m_evicted = m_evicted_reg;
    assign m_slot    = m_slot_reg;

endmodule

// ===== src/tag_report_rate_limiter_core.sv =====
// Top level of the per-address report rate limiter.
//
// Each sighting beat carries a 48-bit tag address and a microsecond time. The block
// scans its table of CACHE_ENTRIES addresses one entry per clock through the read
// port of the table memory, finding a matching entry, else the lowest free entry,
// else the entry with the oldest report time (lowest index on ties). It then checks
// whether report_interval_ms has passed since that entry's last report and writes
// the entry back. After the scan it picks the slot and forms the elapsed time and
// the limit, then decides, then writes back once the output register is free; a
// new sighting is accepted as soon as the previous one has been written back,
// even while its result still waits in the output register. The table is
// empty after reset, and configuration writes are taken in any cycle.
module tag_report_rate_limiter_core #(
    parameter int CACHE_ENTRIES = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [trl_pkg::ADDR_W-1:0]     s_tag_address,
    input  logic [trl_pkg::TIME_W-1:0]     s_now_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_publish,
    output logic                           m_hit,
    output logic                           m_evicted,
    output logic [trl_pkg::SLOT_W-1:0]     m_slot,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trl_pkg::INTERVAL_W-1:0] cfg_data
);
    import trl_pkg::*;

    trl_cmd_t cmd;
    trl_sts_t sts;

    // The interval register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    trl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trl_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_tag_address (s_tag_address),
        .s_now_us      (s_now_us),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_publish     (m_publish),
        .m_hit         (m_hit),
        .m_evicted     (m_evicted),
        .m_slot        (m_slot)
    );

endmodule

// ===== src/trl_checker.sv =====
// Port-level checks for the rate limiter and the bind that attaches them.
module trl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_publish,
    input logic                           m_hit,
    input logic                           m_evicted,
    input logic [trl_pkg::SLOT_W-1:0]     m_slot
);
    import trl_pkg::*;

    // One sighting at a time: input is closed right after a beat is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sighting is in progress");

    // A result appears only when the write-back is done and input reopens.
    a_result_reopens_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) || (m_valid && $past(m_valid && m_ready))) |-> s_ready)
        else $error("result shown while a sighting is still in progress");

    // A hit never evicts.
    a_hit_not_evicted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("result reports both a hit and an eviction");

    // A stalled result beat holds its payload.
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_publish) && $stable(m_hit)
                                   && $stable(m_evicted) && $stable(m_slot)))
        else $error("stalled result beat changed");

endmodule

bind tag_report_rate_limiter_core trl_checker u_trl_checker (.*);
